/* rtl/akf_pkg.sv */
// ============================================================================
// akf_pkg
// Types, constants and helpers shared by the altitude Kalman filter blocks.
// ============================================================================
package akf_pkg;

    // fixed field widths
    localparam int EST_W  = 48;   // Q24.24 estimates
    localparam int COV_W  = 32;   // Q8.24 covariance and gains
    localparam int STEP_W = 24;   // Q0.24 time step
    localparam int NOISE_W = 31;  // unsigned Q7.24 config values
    localparam int ACC_W  = 32;   // Q8.24 acceleration
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 48;
    localparam int FRAC_W = 24;

    // serial unit sizes
    localparam int MUL_A_W = 50;  // multiplicand magnitude
    localparam int MUL_B_W = 34;  // multiplier magnitude, one bit per cycle
    localparam int DIV_N_W = 57;  // dividend, one quotient bit per cycle
    localparam int DIV_D_W = 34;  // divisor magnitude

    localparam logic [STEP_W-1:0]  RST_TIME_STEP = 24'd335544;
    localparam logic [NOISE_W-1:0] RST_Q_ALT     = 31'd167772;
    localparam logic [NOISE_W-1:0] RST_Q_VEL     = 31'd1677722;
    localparam logic [NOISE_W-1:0] RST_R_MEAS    = 31'd4194304;
    localparam logic [NOISE_W-1:0] RST_P_INIT    = 31'd8388608;
    localparam logic signed [COV_W-1:0] HALF_Q24 = 32'sd8388608;
    localparam logic [STEP_W:0]    MAX_STEP      = 25'd8388608;
    localparam logic signed [DIV_D_W-1:0] INNOV_FLOOR = 34'sd17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP   = 4'd0,
        CFG_Q_ALT       = 4'd1,
        CFG_Q_VEL       = 4'd2,
        CFG_R_MEAS      = 4'd3,
        CFG_INIT_ALT    = 4'd4,
        CFG_INIT_VEL    = 4'd5,
        CFG_INIT_P_ALT  = 4'd6,
        CFG_INIT_P_VEL  = 4'd7
    } akf_cfg_e;

    typedef enum logic {
        OP_UPDATE  = 1'b0,
        OP_RESTART = 1'b1
    } akf_op_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } akf_state_e;

    typedef enum logic [4:0] {
        U_DT2,
        U_ALT1,
        U_ALT2,
        U_VEL,
        U_P00A,
        U_P00B,
        U_P00C,
        U_P01,
        U_K0,
        U_K1,
        U_ALT,
        U_VELC,
        U_P0,
        U_P1,
        U_P2,
        U_P3
    } akf_uop_e;

    typedef struct packed {
        logic                      operation;
        logic signed [ACC_W-1:0]   vertical_acceleration;
        logic signed [EST_W-1:0]   barometric_altitude;
        logic [STEP_W-1:0]         step_override;
    } akf_in_t;

    typedef struct packed {
        logic signed [EST_W-1:0]   altitude;
        logic signed [EST_W-1:0]   vertical_velocity;
        logic signed [COV_W-1:0]   altitude_variance;
    } akf_out_t;

    typedef struct packed {
        logic start;
        logic done;
    } akf_unit_ctl_t;

    function automatic logic signed [EST_W-1:0] sat48(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (EST_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi)
            return hi[EST_W-1:0];
        else if (x < lo)
            return lo[EST_W-1:0];
        else
            return x[EST_W-1:0];
    endfunction

    function automatic logic signed [COV_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (COV_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi)
            return hi[COV_W-1:0];
        else if (x < lo)
            return lo[COV_W-1:0];
        else
            return x[COV_W-1:0];
    endfunction

endpackage

/* rtl/akf_mul.sv */
// ============================================================================
// akf_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ============================================================================
module akf_mul
    import akf_pkg::*;
#(
    parameter int A_W = MUL_A_W,
    parameter int B_W = MUL_B_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  akf_unit_ctl_t        ctl_in,
    output logic                 done,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic [A_W+B_W-1:0]   prod
);

    localparam int CNT_W = $clog2(B_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [A_W-1:0]     a_reg, a_next;
    logic [A_W-1:0]     hi_reg, hi_next;
    logic [B_W-1:0]     lo_reg, lo_next;
    logic [A_W:0]       sum;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
        if (ctl_in.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            hi_next   = '0;
            lo_next   = b;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[A_W:1];
            lo_next  = {sum[0], lo_reg[B_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

/* rtl/akf_div.sv */
// ============================================================================
// akf_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ============================================================================
module akf_div
    import akf_pkg::*;
#(
    parameter int N_W = DIV_N_W,
    parameter int D_W = DIV_D_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  akf_unit_ctl_t    ctl_in,
    output logic             done,
    input  logic [N_W-1:0]   dividend,
    input  logic [D_W-1:0]   divisor,
    output logic [N_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(N_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [D_W-1:0]     den_reg, den_next;
    logic [D_W-1:0]     rem_reg, rem_next;
    logic [N_W-1:0]     quo_reg, quo_next;
    logic [D_W:0]       trial;
    logic [D_W:0]       diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        trial = {rem_reg, quo_reg[N_W-1]};
        diff  = trial - {1'b0, den_reg};
        if (ctl_in.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/altitude_kalman_filter.sv */
// ============================================================================
// altitude_kalman_filter
// Two-state (altitude, vertical velocity) Kalman filter, fixed point, with a
// bit-serial multiplier and divider shared by a micro-op sequencer.
// ============================================================================
//  channel   dir  handshake          payload
//  in        in   in_valid/in_stall  akf_in_t  (operation, accel, baro, step)
//  out       out  out_valid/out_stall akf_out_t (altitude, velocity, P00)
//  cfg       in   cfg_valid/cfg_ready cfg_index, cfg_data
//
//  Update item: 14 serial multiplies and 2 divides; the serial multiplier
//  works one multiplier bit per cycle.
//  Restart item: goes straight to the output state. One item at a time; in_stall is high while busy.
//  Result sits in an output register; the next item is accepted meanwhile.
//  Reset: asynchronous, loads configuration defaults and the initial state.
// ============================================================================
module altitude_kalman_filter
    import akf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  akf_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output akf_out_t               out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [MUL_A_W+MUL_B_W-1:0] RND_Q24 = (MUL_A_W+MUL_B_W)'(1) << (FRAC_W - 1);
    localparam logic [MUL_A_W+MUL_B_W-1:0] RND_HALF = (MUL_A_W+MUL_B_W)'(1) << FRAC_W;
    localparam int RND_W = MUL_A_W + MUL_B_W - FRAC_W;

    akf_state_e state_reg, state_next;
    akf_uop_e   uop_reg, uop_next;

    // configuration
    logic [STEP_W-1:0]          cfg_step_reg, cfg_step_next;
    logic [NOISE_W-1:0]         cfg_qa_reg, cfg_qa_next;
    logic [NOISE_W-1:0]         cfg_qv_reg, cfg_qv_next;
    logic [NOISE_W-1:0]         cfg_r_reg, cfg_r_next;
    logic [EST_W-1:0]           cfg_alt_reg, cfg_alt_next;
    logic [EST_W-1:0]           cfg_vel_reg, cfg_vel_next;
    logic [NOISE_W-1:0]         cfg_pa_reg, cfg_pa_next;
    logic [NOISE_W-1:0]         cfg_pv_reg, cfg_pv_next;

    // filter state
    logic signed [EST_W-1:0]    alt_reg, alt_next;
    logic signed [EST_W-1:0]    vel_reg, vel_next;
    logic signed [COV_W-1:0]    p_reg [4];
    logic signed [COV_W-1:0]    p_next [4];
    logic [STEP_W-1:0]          step_reg, step_next;

    // work registers
    logic signed [ACC_W-1:0]    acc_in_reg, acc_in_next;
    logic signed [EST_W-1:0]    baro_reg, baro_next;
    logic [STEP_W:0]            dt2_reg, dt2_next;
    logic [STEP_W-1:0]          hdt2_reg, hdt2_next;
    logic signed [63:0]         sum_reg, sum_next;
    logic signed [EST_W-1:0]    alt_p_reg, alt_p_next;
    logic signed [EST_W-1:0]    vel_p_reg, vel_p_next;
    logic signed [COV_W-1:0]    q_reg [4];
    logic signed [COV_W-1:0]    q_next [4];
    logic signed [EST_W:0]      err_reg, err_next;
    logic signed [DIV_D_W-1:0]  s_reg, s_next;
    logic signed [COV_W-1:0]    k0_reg, k0_next;
    logic signed [COV_W-1:0]    k1_reg, k1_next;
    logic                       neg_reg, neg_next;

    logic                       out_valid_reg, out_valid_next;
    akf_out_t                   out_reg, out_next;

    // serial units
    akf_unit_ctl_t                  mul_ctl, div_ctl;
    logic                           mul_done, div_done;
    logic signed [MUL_A_W-1:0]      mul_a;
    logic signed [MUL_B_W-1:0]      mul_b;
    logic                           mul_sub;
    logic [MUL_A_W-1:0]             mul_a_mag;
    logic [MUL_B_W-1:0]             mul_b_mag;
    logic [MUL_A_W+MUL_B_W-1:0]     mul_prod;
    logic signed [COV_W-1:0]        div_num;
    logic [COV_W-1:0]               div_num_mag;
    logic [DIV_D_W-1:0]             div_den_mag;
    logic [DIV_N_W-1:0]             div_dividend;
    logic [DIV_N_W-1:0]             div_quo;

    logic [RND_W-1:0]               rnd_mag;
    logic signed [63:0]             mul_r;
    logic signed [63:0]             div_q;
    logic signed [DIV_D_W-1:0]      s_raw;
    logic signed [MUL_B_W-1:0]      om;
    logic                           in_fire;
    logic                           is_div;
    logic                           unit_done;
    logic                           out_free;
    logic [STEP_W:0]                ov_ext;

    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_div    = (uop_reg == U_K0) || (uop_reg == U_K1);
    assign unit_done = is_div ? div_done : mul_done;
    assign ov_ext    = {1'b0, in_data.step_override};
    assign om        = MUL_B_W'(1 << FRAC_W) - MUL_B_W'(k0_reg);

    // operand selection for the current micro-op
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_sub = 1'b0;
        case (uop_reg)
            U_DT2:
            begin
                mul_a = MUL_A_W'(step_reg);
                mul_b = MUL_B_W'(step_reg);
            end
            U_ALT1:
            begin
                mul_a = MUL_A_W'(vel_reg);
                mul_b = MUL_B_W'(step_reg);
            end
            U_ALT2:
            begin
                mul_a = MUL_A_W'(acc_in_reg);
                mul_b = MUL_B_W'(hdt2_reg);
            end
            U_VEL:
            begin
                mul_a = MUL_A_W'(acc_in_reg);
                mul_b = MUL_B_W'(step_reg);
            end
            U_P00A:
            begin
                mul_a = MUL_A_W'(p_reg[2]);
                mul_b = MUL_B_W'(step_reg);
            end
            U_P00B:
            begin
                mul_a = MUL_A_W'(p_reg[1]);
                mul_b = MUL_B_W'(step_reg);
            end
            U_P00C:
            begin
                mul_a = MUL_A_W'(p_reg[3]);
                mul_b = MUL_B_W'(dt2_reg);
            end
            U_P01:
            begin
                mul_a = MUL_A_W'(p_reg[3]);
                mul_b = MUL_B_W'(step_reg);
            end
            U_ALT:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(k0_reg);
            end
            U_VELC:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(k1_reg);
            end
            U_P0:
            begin
                mul_a = MUL_A_W'(q_reg[0]);
                mul_b = om;
            end
            U_P1:
            begin
                mul_a = MUL_A_W'(q_reg[1]);
                mul_b = om;
            end
            U_P2:
            begin
                mul_a   = MUL_A_W'(q_reg[0]);
                mul_b   = MUL_B_W'(k1_reg);
                mul_sub = 1'b1;
            end
            U_P3:
            begin
                mul_a   = MUL_A_W'(q_reg[1]);
                mul_b   = MUL_B_W'(k1_reg);
                mul_sub = 1'b1;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_a_mag = mul_a[MUL_A_W-1] ? MUL_A_W'(-mul_a) : MUL_A_W'(mul_a);
    assign mul_b_mag = mul_b[MUL_B_W-1] ? MUL_B_W'(-mul_b) : MUL_B_W'(mul_b);

    assign div_num     = (uop_reg == U_K1) ? q_reg[2] : q_reg[0];
    assign div_num_mag = div_num[COV_W-1] ? COV_W'(-div_num) : COV_W'(div_num);
    assign div_den_mag = s_reg[DIV_D_W-1] ? DIV_D_W'(-s_reg) : DIV_D_W'(s_reg);
    assign div_dividend = (DIV_N_W'(div_num_mag) << FRAC_W) + DIV_N_W'(div_den_mag >> 1);

    // rounded signed product and quotient
    assign rnd_mag = RND_W'((mul_prod + RND_Q24) >> FRAC_W);
    assign mul_r   = neg_reg ? -$signed(64'(rnd_mag)) : $signed(64'(rnd_mag));
    assign div_q   = neg_reg ? -$signed(64'(div_quo)) : $signed(64'(div_quo));

    assign s_raw = DIV_D_W'(q_reg[0]) + DIV_D_W'(cfg_r_reg);

    always_comb
    begin
        state_next     = state_reg;
        uop_next       = uop_reg;
        cfg_step_next  = cfg_step_reg;
        cfg_qa_next    = cfg_qa_reg;
        cfg_qv_next    = cfg_qv_reg;
        cfg_r_next     = cfg_r_reg;
        cfg_alt_next   = cfg_alt_reg;
        cfg_vel_next   = cfg_vel_reg;
        cfg_pa_next    = cfg_pa_reg;
        cfg_pv_next    = cfg_pv_reg;
        alt_next       = alt_reg;
        vel_next       = vel_reg;
        p_next         = p_reg;
        step_next      = step_reg;
        acc_in_next    = acc_in_reg;
        baro_next      = baro_reg;
        dt2_next       = dt2_reg;
        hdt2_next      = hdt2_reg;
        sum_next       = sum_reg;
        alt_p_next     = alt_p_reg;
        vel_p_next     = vel_p_reg;
        q_next         = q_reg;
        err_next       = err_reg;
        s_next         = s_reg;
        k0_next        = k0_reg;
        k1_next        = k1_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mul_ctl        = '0;
        div_ctl        = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cfg_valid)
        begin
            case (akf_cfg_e'(cfg_index))
                CFG_TIME_STEP:  cfg_step_next = cfg_data[STEP_W-1:0];
                CFG_Q_ALT:      cfg_qa_next   = cfg_data[NOISE_W-1:0];
                CFG_Q_VEL:      cfg_qv_next   = cfg_data[NOISE_W-1:0];
                CFG_R_MEAS:     cfg_r_next    = cfg_data[NOISE_W-1:0];
                CFG_INIT_ALT:   cfg_alt_next  = cfg_data[EST_W-1:0];
                CFG_INIT_VEL:   cfg_vel_next  = cfg_data[EST_W-1:0];
                CFG_INIT_P_ALT: cfg_pa_next   = cfg_data[NOISE_W-1:0];
                CFG_INIT_P_VEL: cfg_pv_next   = cfg_data[NOISE_W-1:0];
                default:        cfg_step_next = cfg_step_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (akf_op_e'(in_data.operation) == OP_RESTART)
                    begin
                        alt_next  = $signed(cfg_alt_reg);
                        vel_next  = $signed(cfg_vel_reg);
                        p_next[0] = $signed(COV_W'(cfg_pa_reg));
                        p_next[1] = '0;
                        p_next[2] = '0;
                        p_next[3] = $signed(COV_W'(cfg_pv_reg));
                        step_next = cfg_step_reg;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        acc_in_next = in_data.vertical_acceleration;
                        baro_next   = in_data.barometric_altitude;
                        if (ov_ext != '0 && ov_ext <= MAX_STEP)
                            step_next = in_data.step_override;
                        uop_next   = U_DT2;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                if (is_div)
                begin
                    div_ctl.start = 1'b1;
                    neg_next = div_num[COV_W-1] ^ s_reg[DIV_D_W-1];
                end
                else
                begin
                    mul_ctl.start = 1'b1;
                    neg_next = mul_a[MUL_A_W-1] ^ mul_b[MUL_B_W-1] ^ mul_sub;
                end
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (unit_done)
                begin
                    case (uop_reg)
                        U_DT2:
                        begin
                            dt2_next  = (STEP_W+1)'((mul_prod + RND_Q24) >> FRAC_W);
                            hdt2_next = STEP_W'((mul_prod + RND_HALF) >> (FRAC_W + 1));
                        end
                        U_ALT1: sum_next = 64'(alt_reg) + mul_r;
                        U_ALT2: alt_p_next = sat48(sum_reg + mul_r);
                        U_VEL:  vel_p_next = sat48(64'(vel_reg) + mul_r);
                        U_P00A: sum_next = 64'(p_reg[0]) + mul_r;
                        U_P00B: sum_next = sum_reg + mul_r;
                        U_P00C: q_next[0] = sat32(sum_reg + mul_r
                                                  + $signed(64'(cfg_qa_reg)));
                        U_P01:
                        begin
                            q_next[1] = sat32(64'(p_reg[1]) + mul_r);
                            q_next[2] = sat32(64'(p_reg[2]) + mul_r);
                            q_next[3] = sat32(64'(p_reg[3]) + $signed(64'(cfg_qv_reg)));
                            err_next  = (EST_W+1)'(baro_reg) - (EST_W+1)'(alt_p_reg);
                            // tiny innovation variance is floored
                            if (s_raw < INNOV_FLOOR && s_raw > -INNOV_FLOOR)
                                s_next = INNOV_FLOOR;
                            else
                                s_next = s_raw;
                        end
                        U_K0:   k0_next = sat32(div_q);
                        U_K1:   k1_next = sat32(div_q);
                        U_ALT:  alt_next = sat48(64'(alt_p_reg) + mul_r);
                        U_VELC: vel_next = sat48(64'(vel_p_reg) + mul_r);
                        U_P0:   p_next[0] = sat32(mul_r);
                        U_P1:   p_next[1] = sat32(mul_r);
                        U_P2:   p_next[2] = sat32(64'(q_reg[2]) + mul_r);
                        U_P3:   p_next[3] = sat32(64'(q_reg[3]) + mul_r);
                        default: sum_next = sum_reg;
                    endcase
                    if (uop_reg == U_P3)
                        state_next = ST_OUT;
                    else
                    begin
                        uop_next   = akf_uop_e'(uop_reg + 5'd1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.altitude          = alt_reg;
                    out_next.vertical_velocity = vel_reg;
                    out_next.altitude_variance = p_reg[0];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            uop_reg       <= U_DT2;
            out_valid_reg <= 1'b0;
            cfg_step_reg  <= RST_TIME_STEP;
            cfg_qa_reg    <= RST_Q_ALT;
            cfg_qv_reg    <= RST_Q_VEL;
            cfg_r_reg     <= RST_R_MEAS;
            cfg_alt_reg   <= '0;
            cfg_vel_reg   <= '0;
            cfg_pa_reg    <= RST_P_INIT;
            cfg_pv_reg    <= RST_P_INIT;
            alt_reg       <= '0;
            vel_reg       <= '0;
            p_reg[0]      <= HALF_Q24;
            p_reg[1]      <= '0;
            p_reg[2]      <= '0;
            p_reg[3]      <= HALF_Q24;
            step_reg      <= RST_TIME_STEP;
        end
        else
        begin
            state_reg     <= state_next;
            uop_reg       <= uop_next;
            out_valid_reg <= out_valid_next;
            cfg_step_reg  <= cfg_step_next;
            cfg_qa_reg    <= cfg_qa_next;
            cfg_qv_reg    <= cfg_qv_next;
            cfg_r_reg     <= cfg_r_next;
            cfg_alt_reg   <= cfg_alt_next;
            cfg_vel_reg   <= cfg_vel_next;
            cfg_pa_reg    <= cfg_pa_next;
            cfg_pv_reg    <= cfg_pv_next;
            alt_reg       <= alt_next;
            vel_reg       <= vel_next;
            p_reg         <= p_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_in_reg <= acc_in_next;
        baro_reg   <= baro_next;
        dt2_reg    <= dt2_next;
        hdt2_reg   <= hdt2_next;
        sum_reg    <= sum_next;
        alt_p_reg  <= alt_p_next;
        vel_p_reg  <= vel_p_next;
        q_reg      <= q_next;
        err_reg    <= err_next;
        s_reg      <= s_next;
        k0_reg     <= k0_next;
        k1_reg     <= k1_next;
        neg_reg    <= neg_next;
        out_reg    <= out_next;
    end

    akf_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (mul_ctl),
        .done   (mul_done),
        .a      (mul_a_mag),
        .b      (mul_b_mag),
        .prod   (mul_prod)
    );

    akf_div #(
        .N_W (DIV_N_W),
        .D_W (DIV_D_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (div_ctl),
        .done     (div_done),
        .dividend (div_dividend),
        .divisor  (div_den_mag),
        .quotient (div_quo)
    );

`ifndef SYNTHESIS
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_OUT))
        else $error("result item raised outside the output state");

    a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_WAIT && !is_div))
        else $error("multiplier finished while not awaited");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_WAIT && is_div))
        else $error("divider finished while not awaited");

    a_restart_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.operation) |=> (state_reg == ST_OUT))
        else $error("restart item did not go straight to output");
`endif

endmodule

/* bench/akf_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// akf_checker
// Watches the config, input and result channels of the altitude Kalman
// filter, runs a fixed-point model of the filter on every accepted item and
// compares each accepted result field by field with the oldest prediction.
// ============================================================================
module akf_checker
    import akf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  akf_in_t                in_data,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  akf_out_t               out_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     errors,
    output int                     pending
);

    localparam longint ONE_Q = 64'sd1 <<< FRAC_W;

    logic [CFG_DATA_W-1:0] reg_val [8];
    longint                alt_est;
    longint                vel_est;
    longint                cov [4];
    logic [STEP_W-1:0]     step;
    akf_out_t              estimates [$];

    assign pending = estimates.size();

    function automatic longint sat_w(longint x, int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        return (x > hi) ? hi : ((x < lo) ? lo : x);
    endfunction

    function automatic longint unsigned magnitude(longint x);
        return (x < 0) ? longint'(-x) : x;
    endfunction

    // (a*b)/2^24, round half away from zero
    function automatic longint mul_q24(longint a, longint b);
        longint unsigned m;
        longint unsigned n;
        longint unsigned r;
        m = magnitude(a);
        n = magnitude(b);
        r = (m >> 24) * n + (((m & 64'hFFFFFF) * n + 64'h800000) >> 24);
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint div_q24(longint num, longint den);
        longint unsigned m;
        longint unsigned n;
        longint unsigned q;
        m = magnitude(num) << 24;
        n = magnitude(den);
        q = (m + n / 2) / n;
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic int reg_width(int idx);
        case (idx)
            CFG_TIME_STEP:               return STEP_W;
            CFG_INIT_ALT, CFG_INIT_VEL:  return EST_W;
            default:                     return NOISE_W;
        endcase
    endfunction

    task automatic filter_step(input akf_in_t it, output akf_out_t res);
        longint acc, baro, dt, dt2, hdt2, alt, vel;
        longint p00, p01, p10, p11, s, k0, k1, err, om;
        if (it.operation == OP_RESTART) begin
            alt_est = longint'($signed(reg_val[CFG_INIT_ALT]));
            vel_est = longint'($signed(reg_val[CFG_INIT_VEL]));
            cov[0]  = longint'(reg_val[CFG_INIT_P_ALT][NOISE_W-1:0]);
            cov[1]  = 0;
            cov[2]  = 0;
            cov[3]  = longint'(reg_val[CFG_INIT_P_VEL][NOISE_W-1:0]);
            step    = reg_val[CFG_TIME_STEP][STEP_W-1:0];
        end
        else begin
            acc  = longint'(it.vertical_acceleration);
            baro = longint'(it.barometric_altitude);
            if (it.step_override != 0 && {1'b0, it.step_override} <= MAX_STEP)
                step = it.step_override;
            dt   = longint'(step);
            dt2  = (dt * dt + longint'(HALF_Q24)) / ONE_Q;
            hdt2 = (dt * dt + ONE_Q) / (2 * ONE_Q);

            alt = sat_w(alt_est + mul_q24(vel_est, dt) + mul_q24(acc, hdt2), EST_W);
            vel = sat_w(vel_est + mul_q24(acc, dt), EST_W);
            p00 = sat_w(cov[0] + mul_q24(cov[2], dt) + mul_q24(cov[1], dt)
                        + mul_q24(cov[3], dt2)
                        + longint'(reg_val[CFG_Q_ALT][NOISE_W-1:0]), COV_W);
            p01 = sat_w(cov[1] + mul_q24(cov[3], dt), COV_W);
            p10 = sat_w(cov[2] + mul_q24(cov[3], dt), COV_W);
            p11 = sat_w(cov[3] + longint'(reg_val[CFG_Q_VEL][NOISE_W-1:0]), COV_W);

            err = baro - alt;
            s   = p00 + longint'(reg_val[CFG_R_MEAS][NOISE_W-1:0]);
            if (s < longint'(INNOV_FLOOR) && s > -longint'(INNOV_FLOOR))
                s = longint'(INNOV_FLOOR);
            k0 = sat_w(div_q24(p00, s), COV_W);
            k1 = sat_w(div_q24(p10, s), COV_W);
            alt_est = sat_w(alt + mul_q24(err, k0), EST_W);
            vel_est = sat_w(vel + mul_q24(err, k1), EST_W);
            om = ONE_Q - k0;
            cov[0] = sat_w(mul_q24(om, p00), COV_W);
            cov[1] = sat_w(mul_q24(om, p01), COV_W);
            cov[2] = sat_w(p10 - mul_q24(k1, p00), COV_W);
            cov[3] = sat_w(p11 - mul_q24(k1, p01), COV_W);
        end
        res.altitude          = alt_est[EST_W-1:0];
        res.vertical_velocity = vel_est[EST_W-1:0];
        res.altitude_variance = cov[0][COV_W-1:0];
    endtask

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t: %s mismatch: got %0d expected %0d", $time, field, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        akf_out_t want;
        akf_out_t next_est;
        if (!rst_n) begin
            reg_val[CFG_TIME_STEP]  = 48'(RST_TIME_STEP);
            reg_val[CFG_Q_ALT]      = 48'(RST_Q_ALT);
            reg_val[CFG_Q_VEL]      = 48'(RST_Q_VEL);
            reg_val[CFG_R_MEAS]     = 48'(RST_R_MEAS);
            reg_val[CFG_INIT_ALT]   = '0;
            reg_val[CFG_INIT_VEL]   = '0;
            reg_val[CFG_INIT_P_ALT] = 48'(RST_P_INIT);
            reg_val[CFG_INIT_P_VEL] = 48'(RST_P_INIT);
            alt_est = 0;
            vel_est = 0;
            cov[0]  = longint'(HALF_Q24);
            cov[1]  = 0;
            cov[2]  = 0;
            cov[3]  = longint'(HALF_Q24);
            step    = RST_TIME_STEP;
            estimates.delete();
        end
        else begin
            if (cfg_valid && cfg_ready && cfg_index <= CFG_INIT_P_VEL)
                reg_val[cfg_index] = cfg_data & ((48'd1 << reg_width(cfg_index)) - 48'd1);
            if (out_valid && !out_stall) begin
                if (estimates.size() == 0) begin
                    $display("%0t: result item with nothing expected", $time);
                    errors++;
                end
                else begin
                    want = estimates.pop_front();
                    if (out_data.altitude !== want.altitude)
                        report_mismatch("altitude", out_data.altitude, want.altitude);
                    if (out_data.vertical_velocity !== want.vertical_velocity)
                        report_mismatch("vertical_velocity", out_data.vertical_velocity,
                                        want.vertical_velocity);
                    if (out_data.altitude_variance !== want.altitude_variance)
                        report_mismatch("altitude_variance", out_data.altitude_variance,
                                        want.altitude_variance);
                end
            end
            if (in_valid && !in_stall) begin
                filter_step(in_data, next_est);
                estimates.push_back(next_est);
            end
        end
    end

    initial errors = 0;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives the altitude Kalman filter through several register settings with
// directed and random update/restart items, random idling on both sides and
// one long result hold-off; the checker predicts and compares the results.
// ============================================================================
module testbench;
    import akf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 700;
    localparam int HOLD_CYCLES    = 3000;
    localparam int RANDOM_ITEMS   = 330;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    akf_in_t               in_data;
    logic                  out_valid;
    logic                  out_stall;
    akf_out_t              out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    in_idle_pct;
    int                    out_idle_pct;
    bit                    hold_request;
    int                    quiet_cycles;

    altitude_kalman_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    akf_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stall, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_stall = 1'b1;
            end
            else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                out_stall = 1'b1;
            end
            else
                out_stall = ($urandom_range(99) < out_idle_pct);
        end
    end

    // watchdog: cycles in a row with nothing accepted on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic akf_in_t make_item(akf_op_e op, logic [ACC_W-1:0] acc,
                                          logic [EST_W-1:0] baro, logic [STEP_W-1:0] ov);
        akf_in_t it;
        it.operation             = op;
        it.vertical_acceleration = acc;
        it.barometric_altitude   = baro;
        it.step_override         = ov;
        return it;
    endfunction

    function automatic akf_in_t random_item();
        logic [ACC_W-1:0]  acc;
        logic [EST_W-1:0]  baro;
        logic [STEP_W-1:0] ov;
        akf_op_e           op;
        int                pick;
        op  = ($urandom_range(99) < 10) ? OP_RESTART : OP_UPDATE;
        acc = ($urandom_range(1)) ? $urandom : 32'($signed(26'($urandom)));
        baro = 48'({$urandom, $urandom});
        if ($urandom_range(1))
            baro = 48'($signed(34'({$urandom, $urandom})));
        pick = $urandom_range(99);
        if (pick < 40)
            ov = '0;
        else if (pick < 70)
            ov = STEP_W'($urandom_range(1, MAX_STEP));
        else if (pick < 85)
            ov = MAX_STEP[STEP_W-1:0] + STEP_W'($urandom_range(1));
        else
            ov = STEP_W'($urandom);
        return make_item(op, acc, baro, ov);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send(akf_in_t it);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_regs(int phase);
        case (phase)
            0: begin
                write_reg(CFG_TIME_STEP,  48'(RST_TIME_STEP));
                write_reg(CFG_Q_ALT,      48'(RST_Q_ALT));
                write_reg(CFG_Q_VEL,      48'(RST_Q_VEL));
                write_reg(CFG_R_MEAS,     48'(RST_R_MEAS));
                write_reg(CFG_INIT_ALT,   '0);
                write_reg(CFG_INIT_VEL,   '0);
                write_reg(CFG_INIT_P_ALT, 48'(RST_P_INIT));
                write_reg(CFG_INIT_P_VEL, 48'(RST_P_INIT));
            end
            1: begin
                // extreme values, with junk above the width of each register narrower than the data
                write_reg(CFG_TIME_STEP,  '1);
                write_reg(CFG_Q_ALT,      '1);
                write_reg(CFG_Q_VEL,      '1);
                write_reg(CFG_R_MEAS,     '1);
                write_reg(CFG_INIT_ALT,   48'h7FFF_FFFF_FFFF);
                write_reg(CFG_INIT_VEL,   48'h8000_0000_0000);
                write_reg(CFG_INIT_P_ALT, '1);
                write_reg(CFG_INIT_P_VEL, '1);
            end
            2: begin
                // zero noise and variance drives the innovation floor
                write_reg(CFG_TIME_STEP,  '0);
                write_reg(CFG_Q_ALT,      '0);
                write_reg(CFG_Q_VEL,      '0);
                write_reg(CFG_R_MEAS,     '0);
                write_reg(CFG_INIT_ALT,   '0);
                write_reg(CFG_INIT_VEL,   '0);
                write_reg(CFG_INIT_P_ALT, '0);
                write_reg(CFG_INIT_P_VEL, '0);
                write_reg(CFG_UNUSED,     '1);
            end
            default: begin
                write_reg(CFG_TIME_STEP,  48'($urandom_range(1, MAX_STEP)));
                write_reg(CFG_Q_ALT,      48'($urandom_range(0, 1 << 26)));
                write_reg(CFG_Q_VEL,      48'($urandom_range(0, 1 << 26)));
                write_reg(CFG_R_MEAS,     48'($urandom_range(0, 1 << 28)));
                write_reg(CFG_INIT_ALT,   48'({$urandom, $urandom}));
                write_reg(CFG_INIT_VEL,   48'($signed(36'({$urandom, $urandom}))));
                write_reg(CFG_INIT_P_ALT, 48'($urandom_range(0, 1 << 27)));
                write_reg(CFG_INIT_P_VEL, 48'($urandom));
            end
        endcase
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_idle_pct  = 33;
        out_idle_pct = 33;
        hold_request = 1'b0;
        quiet_cycles = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // state straight out of reset
        send(make_item(OP_UPDATE, 32'd1 << 24, 48'd5 << 24, '0));

        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            set_regs(phase);
            in_idle_pct  = (phase == 4) ? 0 : 33;
            out_idle_pct = (phase == 4) ? 0 : 33;
            send(make_item(OP_RESTART, $urandom, 48'({$urandom, $urandom}),
                           STEP_W'($urandom)));
            send(make_item(OP_UPDATE, '0, '0, '0));
            if (phase == 0) begin
                send(make_item(OP_UPDATE, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, '0));
                send(make_item(OP_UPDATE, 32'h8000_0000, 48'h8000_0000_0000, 24'd1));
                send(make_item(OP_UPDATE, 32'h0100_0000, 48'd100 << 24, MAX_STEP[23:0]));
                send(make_item(OP_UPDATE, 32'hFF00_0000, 48'd90 << 24,
                               MAX_STEP[23:0] + 24'd1));
                send(make_item(OP_UPDATE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF));
                send(make_item(OP_UPDATE, '0, 48'd1, 24'd335544));
                send(make_item(OP_RESTART, '0, '0, '0));
                send(make_item(OP_UPDATE, 32'h0000_0001, 48'h0000_FFFF_FFFF, 24'h55_5555));
                send(make_item(OP_UPDATE, 32'h5555_5555, 48'h5555_5555_5555, 24'h2A_AAAA));
                send(make_item(OP_UPDATE, 32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA, 24'h80_0000));
            end
            if (phase == 3)
                hold_request = 1'b1;
            for (int n = 0; n < RANDOM_ITEMS; n++)
                send(random_item());
        end

        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
rtl/akf_pkg.sv
rtl/akf_mul.sv
rtl/akf_div.sv
rtl/altitude_kalman_filter.sv
bench/akf_checker.sv
bench/testbench.sv
